[rtl/core/mrx_pkg.sv]
// Shared types, constants and register codes for the Manchester RF byte receiver.
// No dependencies; mrx_cfg, mrx_mem, mrx_ctrl and the top level import it.
`default_nettype none
package mrx_pkg;

  localparam int FIFO_DEPTH_DEF = 16;
  localparam int BYTE_W = 8;
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;
  localparam int PHASE_W = 3;
  localparam int BITCNT_W = 4;

  // phase codes
  localparam logic [PHASE_W-1:0] PH_INIT      = 3'd0;
  localparam logic [PHASE_W-1:0] PH_WAIT_HIGH = 3'd1;
  localparam logic [PHASE_W-1:0] PH_HIGH      = 3'd2;
  localparam logic [PHASE_W-1:0] PH_LOW       = 3'd3;
  localparam logic [PHASE_W-1:0] PH_EDGE      = 3'd4;
  localparam logic [PHASE_W-1:0] PH_BIT       = 3'd5;
  localparam logic [PHASE_W-1:0] PH_RESYNC    = 3'd6;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_HIGH_MIN = 3'd0;
  localparam logic [2:0] REG_LOW_MIN  = 3'd1;
  localparam logic [2:0] REG_LOW_MAX  = 3'd2;
  localparam logic [2:0] REG_RESYNC   = 3'd3;
  localparam logic [2:0] REG_END_BYTE = 3'd4;

  localparam logic [BYTE_W-1:0] RST_HIGH_MIN = 8'd9;
  localparam logic [BYTE_W-1:0] RST_LOW_MIN  = 8'd13;
  localparam logic [BYTE_W-1:0] RST_LOW_MAX  = 8'd17;
  localparam logic [BYTE_W-1:0] RST_RESYNC   = 8'd8;
  localparam logic [BYTE_W-1:0] RST_END_BYTE = 8'h06;

  localparam logic [BYTE_W-1:0] TICK_MAX = 8'hFF;

  typedef struct packed {
    logic [BYTE_W-1:0] high_min;
    logic [BYTE_W-1:0] low_min;
    logic [BYTE_W-1:0] low_max;
    logic [BYTE_W-1:0] resync;
    logic [BYTE_W-1:0] end_byte;
  } cfg_t;

  // per-request status from the phase machine
  typedef struct packed {
    logic              byte_done;
    logic [BYTE_W-1:0] done_byte;
    logic              frame_end;
    logic              overflow;
    logic              pop_empty;
    logic              pop_ok;
    logic              fwd;
  } step_t;

endpackage
`default_nettype wire

[rtl/core/mrx_in_if.sv]
// Request channel of the receiver: one line poll per request.
// Depends on nothing.
`default_nettype none
interface mrx_in_if;
  logic valid;
  logic ready;
  logic line_level;
  logic tick;
  logic pop_req;

  modport source(output valid, output line_level, output tick, output pop_req, input ready);
  modport sink(input valid, input line_level, input tick, input pop_req, output ready);
endinterface
`default_nettype wire

[rtl/core/mrx_out_if.sv]
// Result channel of the receiver.
// Depends on nothing; CNT_W follows from the FIFO depth.
`default_nettype none
interface mrx_out_if #(
  parameter int CNT_W = 5
);
  logic             valid;
  logic             ready;
  logic             byte_done;
  logic [7:0]       done_byte;
  logic             frame_end;
  logic [7:0]       pop_data;
  logic             pop_empty;
  logic             overflow;
  logic [CNT_W-1:0] fill_count;

  modport source(output valid, output byte_done, output done_byte, output frame_end,
                 output pop_data, output pop_empty, output overflow, output fill_count,
                 input ready);
  modport sink(input valid, input byte_done, input done_byte, input frame_end,
               input pop_data, input pop_empty, input overflow, input fill_count,
               output ready);
endinterface
`default_nettype wire

[rtl/core/mrx_cfg.sv]
// APB-style configuration registers of the receiver.
// Depends on mrx_pkg.
`default_nettype none
module mrx_cfg
  import mrx_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.high_min <= RST_HIGH_MIN;
      cfg.low_min  <= RST_LOW_MIN;
      cfg.low_max  <= RST_LOW_MAX;
      cfg.resync   <= RST_RESYNC;
      cfg.end_byte <= RST_END_BYTE;
    end else if (wr) begin
      case (idx)
        REG_HIGH_MIN: cfg.high_min <= pwdata[BYTE_W-1:0];
        REG_LOW_MIN:  cfg.low_min  <= pwdata[BYTE_W-1:0];
        REG_LOW_MAX:  cfg.low_max  <= pwdata[BYTE_W-1:0];
        REG_RESYNC:   cfg.resync   <= pwdata[BYTE_W-1:0];
        REG_END_BYTE: cfg.end_byte <= pwdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_HIGH_MIN: prdata = {{(APB_DW-BYTE_W){1'b0}}, cfg.high_min};
      REG_LOW_MIN:  prdata = {{(APB_DW-BYTE_W){1'b0}}, cfg.low_min};
      REG_LOW_MAX:  prdata = {{(APB_DW-BYTE_W){1'b0}}, cfg.low_max};
      REG_RESYNC:   prdata = {{(APB_DW-BYTE_W){1'b0}}, cfg.resync};
      REG_END_BYTE: prdata = {{(APB_DW-BYTE_W){1'b0}}, cfg.end_byte};
      default:      prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

[rtl/core/mrx_mem.sv]
// Receive FIFO storage: one write port, one read port, registered read data.
// Depends on mrx_pkg.
`default_nettype none
module mrx_mem
  import mrx_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH_DEF,
  parameter int AW    = 4
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [BYTE_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output logic [BYTE_W-1:0]      rdata
);

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/core/mrx_ctrl.sv]
// Start-pulse check, Manchester bit decode and FIFO pointer control.
// Depends on mrx_pkg; drives the ports of mrx_mem.
`default_nettype none
module mrx_ctrl
  import mrx_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH_DEF,
  parameter int AW    = 4,
  parameter int CNT_W = 5
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic              line_level,
  input  wire logic              tick,
  input  wire logic              pop_req,
  input  wire cfg_t              cfg,
  output step_t                  step,
  output logic [CNT_W-1:0]       fill_next,
  output logic                   mem_we,
  output logic [AW-1:0]          mem_waddr,
  output logic [BYTE_W-1:0]      mem_wdata,
  output logic                   mem_re,
  output logic [AW-1:0]          mem_raddr
);

  logic [PHASE_W-1:0]  phase, phase_next;
  logic [BYTE_W-1:0]   elapsed, elapsed_next, et_inc;
  logic [BYTE_W-1:0]   shift_byte, shift_byte_next;
  logic [BITCNT_W-1:0] bit_count, bit_count_next;
  logic                prev_level, prev_level_next;
  logic [AW-1:0]       wr_ptr, wr_ptr_next, rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0]    count, count_next, count_pushed;
  logic                push;

  always_comb begin
    et_inc = (tick && elapsed != TICK_MAX) ? elapsed + 8'd1 : elapsed;
    phase_next      = phase;
    elapsed_next    = et_inc;
    shift_byte_next = shift_byte;
    bit_count_next  = bit_count;
    prev_level_next = prev_level;
    step            = '0;
    push            = 1'b0;

    case (phase)
      PH_WAIT_HIGH: begin
        if (line_level) begin
          elapsed_next = '0;
          phase_next   = PH_HIGH;
        end
      end
      PH_HIGH: begin
        if (!line_level) begin
          prev_level_next = 1'b0;
          if (et_inc >= cfg.high_min) begin
            elapsed_next = '0;
            phase_next   = PH_LOW;
          end else begin
            phase_next = PH_INIT;
          end
        end
      end
      PH_LOW: begin
        if (line_level) begin
          if (et_inc >= cfg.low_min && et_inc <= cfg.low_max) begin
            elapsed_next = '0;
            phase_next   = PH_EDGE;
          end else begin
            phase_next = PH_INIT;
          end
        end
      end
      PH_EDGE: begin
        if (prev_level != line_level) begin
          elapsed_next    = '0;
          shift_byte_next = {line_level, shift_byte[BYTE_W-1:1]};
          bit_count_next  = bit_count + 4'd1;
          phase_next      = PH_BIT;
        end
      end
      PH_BIT: begin
        phase_next = PH_RESYNC;
        if (bit_count[3]) begin
          bit_count_next  = '0;
          step.byte_done  = 1'b1;
          step.done_byte  = shift_byte;
          step.frame_end  = (shift_byte == cfg.end_byte);
          if (count != CNT_W'(DEPTH)) begin
            push = 1'b1;
          end else begin
            step.overflow = 1'b1;
          end
          if (shift_byte == cfg.end_byte) begin
            phase_next = PH_INIT;
          end
        end
      end
      PH_RESYNC: begin
        if (et_inc >= cfg.resync) begin
          elapsed_next    = '0;
          prev_level_next = line_level;
          phase_next      = PH_EDGE;
        end
      end
      default: begin
        bit_count_next  = '0;
        shift_byte_next = '0;
        phase_next      = PH_WAIT_HIGH;
      end
    endcase

    count_pushed   = count + CNT_W'(push);
    step.pop_ok    = pop_req && (count_pushed != '0);
    step.pop_empty = pop_req && (count_pushed == '0);
    // entry pushed and popped in the same request: read port sees stale data
    step.fwd       = push && step.pop_ok && (count == '0);
    count_next     = count_pushed - CNT_W'(step.pop_ok);
    wr_ptr_next    = push ? ((wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1)) : wr_ptr;
    rd_ptr_next    = step.pop_ok ?
                     ((rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1)) : rd_ptr;
  end

  assign fill_next = count_next;
  assign mem_we    = accept && push;
  assign mem_waddr = wr_ptr;
  assign mem_wdata = shift_byte;
  assign mem_re    = accept && step.pop_ok;
  assign mem_raddr = rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_INIT;
      elapsed    <= '0;
      shift_byte <= '0;
      bit_count  <= '0;
      prev_level <= 1'b0;
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      count      <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      elapsed    <= elapsed_next;
      shift_byte <= shift_byte_next;
      bit_count  <= bit_count_next;
      prev_level <= prev_level_next;
      wr_ptr     <= wr_ptr_next;
      rd_ptr     <= rd_ptr_next;
      count      <= count_next;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("fifo count above depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> wr_ptr == rd_ptr)
    else $error("empty fifo with unequal pointers");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    accept && step.overflow |=> count == CNT_W'(DEPTH) || $past(pop_req))
    else $error("overflow flagged on a fifo that was not full");

  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> count != CNT_W'(DEPTH))
    else $error("write into a full fifo");

endmodule
`default_nettype wire

[rtl/core/manchester_rf_byte_receiver_top.sv]
// Top level of the Manchester RF byte receiver: config port, phase machine,
// FIFO memory and result registers. Depends on mrx_pkg, mrx_in_if, mrx_out_if,
// mrx_cfg, mrx_ctrl and mrx_mem.
//
// Usage: each request on rx is one poll of the RF line (line_level), a tick
// flag and a pop request. Each request gives exactly one result on res:
// byte_done/done_byte/frame_end for a byte completed by this poll, pop_data
// and pop_empty for the pop, overflow if the byte was dropped on a full FIFO,
// and fill_count after the step.
// Throughput: one request per cycle while res is not stalled. The state update
// and FIFO read happen at the accepting edge into the middle stage; the result
// register is loaded from there when that stage advances. A byte pushed and
// popped in the same request is forwarded past the FIFO read port.
// Reset (rst, synchronous) returns the registers to their defaults, empties
// the FIFO and puts the receiver in its idle state.
// When res is stalled, one more request is taken into the middle stage; rx
// then holds ready low until res drains.
// The user writes registers over APB only while no request is in flight; the block does not enforce it.
`default_nettype none
module manchester_rf_byte_receiver_top
  import mrx_pkg::*;
#(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
  parameter int AW         = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1,
  parameter int CNT_W      = $clog2(FIFO_DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  mrx_in_if.sink                 rx,
  mrx_out_if.source              res,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  cfg_t              cfg;
  step_t             step, a_step;
  logic [CNT_W-1:0]  fill_next, a_fill;
  logic              accept, a_valid, adv;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [BYTE_W-1:0] mem_wdata, mem_rdata;

  mrx_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  mrx_ctrl #(.DEPTH(FIFO_DEPTH), .AW(AW), .CNT_W(CNT_W)) u_ctrl (
    .clk, .rst, .accept,
    .line_level (rx.line_level),
    .tick       (rx.tick),
    .pop_req    (rx.pop_req),
    .cfg, .step, .fill_next,
    .mem_we, .mem_waddr, .mem_wdata, .mem_re, .mem_raddr
  );

  mrx_mem #(.DEPTH(FIFO_DEPTH), .AW(AW)) u_mem (
    .clk,
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign adv      = a_valid && (!res.valid || res.ready);
  assign rx.ready = !a_valid || adv;
  assign accept   = rx.valid && rx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= accept || (a_valid && !adv);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_step <= step;
      a_fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      res.valid <= adv || (res.valid && !res.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res.byte_done  <= a_step.byte_done;
      res.done_byte  <= a_step.done_byte;
      res.frame_end  <= a_step.frame_end;
      res.overflow   <= a_step.overflow;
      res.pop_empty  <= a_step.pop_empty;
      res.fill_count <= a_fill;
      res.pop_data   <= a_step.fwd ? a_step.done_byte :
                        (a_step.pop_ok ? mem_rdata : '0);
    end
  end

  a_fwd_needs_push: assert property (@(posedge clk) disable iff (rst)
    a_valid && a_step.fwd |-> a_step.byte_done && !a_step.overflow && a_step.pop_ok)
    else $error("forward without a push and pop");

  a_pop_flags: assert property (@(posedge clk) disable iff (rst)
    a_valid |-> !(a_step.pop_ok && a_step.pop_empty))
    else $error("pop both served and empty");

  a_no_accept_full: assert property (@(posedge clk) disable iff (rst)
    a_valid && res.valid && !res.ready |-> !rx.ready)
    else $error("request taken with both stages full");

endmodule
`default_nettype wire
